/* rtl/atmr_pkg.sv */
package atmr_pkg;
	localparam int SUM_W = 40;
	localparam int RMS_W = 20;
	localparam int WIN_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DC_RANGE = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DC_OVER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AC_RANGE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_AC_OVER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DIVISOR  = 3'd6;

	localparam logic [1:0] RANGE_LOW  = 2'd0;
	localparam logic [1:0] RANGE_HIGH = 2'd1;
	localparam logic [1:0] RANGE_OVER = 2'd2;
	localparam logic [1:0] RANGE_NONE = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SORT,
		ST_MEAN,
		ST_DIV,
		ST_SQRT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [SUM_W-1:0] dividend;
		logic [WIN_W-1:0] divisor;
	} div_req_t;
endpackage

/* rtl/atmr_divsqrt.sv */
// bit-serial restoring divide, then bit-serial integer square root
module atmr_divsqrt (
	input  logic clk,
	input  logic arst_n,
	input  atmr_pkg::div_req_t req,
	output logic busy,
	output logic done,
	output logic [atmr_pkg::RMS_W-1:0] root
);
	import atmr_pkg::*;
	localparam int CNT_W = $clog2(SUM_W + 1);

	logic phase_q;
	logic run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] quo_q;
	logic [WIN_W:0] rem_q;
	logic [WIN_W-1:0] den_q;
	logic [RMS_W+1:0] srem_q;
	logic [RMS_W-1:0] res_q;
	logic done_q;

	logic [WIN_W:0] rem_sh;
	logic [RMS_W+1:0] srem_sh;
	logic [RMS_W+1:0] trial;

	assign rem_sh  = {rem_q[WIN_W-1:0], quo_q[SUM_W-1]};
	assign srem_sh = {srem_q[RMS_W-1:0], quo_q[SUM_W-1:SUM_W-2]};
	assign trial   = {res_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			phase_q <= 1'b0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !run_q) begin
				run_q   <= 1'b1;
				phase_q <= 1'b0;
				cnt_q   <= CNT_W'(SUM_W);
			end else if (run_q) begin
				if (!phase_q) begin
					if (cnt_q == CNT_W'(1)) begin
						phase_q <= 1'b1;
						cnt_q   <= CNT_W'(SUM_W / 2);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end else begin
					if (cnt_q == CNT_W'(1)) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !run_q) begin
			quo_q  <= req.dividend;
			rem_q  <= '0;
			den_q  <= (req.divisor == '0) ? WIN_W'(1) : req.divisor;
			srem_q <= '0;
			res_q  <= '0;
		end else if (run_q && !phase_q) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				quo_q <= {quo_q[SUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SUM_W-2:0], 1'b0};
			end
		end else if (run_q) begin
			// two quotient bits per root bit
			quo_q <= {quo_q[SUM_W-3:0], 2'b00};
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial;
				res_q  <= {res_q[RMS_W-2:0], 1'b1};
			end else begin
				srem_q <= srem_sh;
				res_q  <= {res_q[RMS_W-2:0], 1'b0};
			end
		end
	end

	assign busy = run_q;
	assign done = done_q;
	assign root = res_q;

`ifndef NO_ASSERTIONS
	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !run_q) else $error("done while running");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.start && !run_q) |=> (run_q && !phase_q)) else $error("start lost");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held");
`endif
endmodule

/* rtl/adc_trimmed_mean_rms_autorange_unit.sv */
// each accepted item runs an odd-even transposition sort, one stage a cycle, then a serial
// divide by three over ADC_BITS+2 bits
// an item that closes a window also runs the 40-step divide and 20-step root
// one item in flight at a time; output register frees input while the result waits
// arst_n returns the control and config registers to their reset values; data registers are not reset
module adc_trimmed_mean_rms_autorange_unit #(
	parameter int SAMPLES_PER_TICK = 5,
	parameter int ADC_BITS = 12
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [((SAMPLES_PER_TICK*ADC_BITS+7)/8)*8-1:0] s_tdata, // sample_a..sample_e
	output logic m_tvalid,
	input  logic m_tready,
	// filtered_code(ADC_BITS), range_code, rms_code(20), pad
	output logic [((ADC_BITS+2+atmr_pkg::RMS_W+7)/8)*8-1:0] m_tdata,
	output logic [0:0] m_tuser, // range_changed
	output logic m_tlast, // rms_updated
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [atmr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [atmr_pkg::CFG_DATA_W-1:0] cfg_data
);
	import atmr_pkg::*;
	localparam int N = SAMPLES_PER_TICK;
	localparam int START = (N - 3) / 2;
	localparam int MW = ADC_BITS + 2;
	localparam int SQ_W = 2 * ADC_BITS;
	localparam int SC_W = $clog2(N + 1);
	localparam int MC_W = $clog2(MW + 1);
	localparam int OUT_BITS = ADC_BITS + 2 + RMS_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	logic mode_q;
	logic [12:0] dc_range_q, dc_over_q;
	logic [RMS_W-1:0] ac_range_q, ac_over_q;
	logic [WIN_W-1:0] window_q, divisor_q;

	logic [WIN_W-1:0] wcount_q;
	logic [SUM_W-1:0] sum_q;
	logic [RMS_W-1:0] held_q;
	logic [1:0] prev_q;

	state_t state_q, state_d;
	logic [ADC_BITS-1:0] s_q [N];
	logic [SC_W-1:0] scnt_q;
	logic [MC_W-1:0] mcnt_q;
	logic [MW-1:0] msum_q, mquo_q;
	logic [1:0] mrem_q;
	logic [SQ_W-1:0] sq_s1;
	logic upd_q;

	logic out_full_q;
	logic [ADC_BITS-1:0] o_filt_q;
	logic [1:0] o_range_q;
	logic o_chg_q;
	logic [RMS_W-1:0] o_rms_q;
	logic o_upd_q;

	div_req_t dreq;
	logic dbusy, ddone;
	logic [RMS_W-1:0] droot;

	logic accept, go_out;
	logic [2:0] mrem_sh;
	logic [ADC_BITS-1:0] filt;
	logic [1:0] range;
	logic [SUM_W:0] sum_add;
	logic [ADC_BITS-1:0] s_sw [N];

	assign accept = s_tvalid && s_tready;
	assign filt = mquo_q[ADC_BITS-1:0];
	assign mrem_sh = {mrem_q, msum_q[MW-1]};
	assign cfg_ready = 1'b1;

	// one transposition stage; parity alternates with the counter
	always_comb begin
		for (int k = 0; k < N; k++) s_sw[k] = s_q[k];
		for (int k = 0; k + 1 < N; k++) begin
			if ((k % 2) == int'(scnt_q[0]) && s_q[k] > s_q[k+1]) begin
				s_sw[k]   = s_q[k+1];
				s_sw[k+1] = s_q[k];
			end
		end
	end

	atmr_divsqrt u_divsqrt (
		.clk(clk), .arst_n(arst_n), .req(dreq),
		.busy(dbusy), .done(ddone), .root(droot)
	);

	assign dreq.start = (state_q == ST_MEAN) && (mcnt_q == '0) && (wcount_q >= window_q);
	assign dreq.dividend = sum_q;
	assign dreq.divisor = divisor_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept) state_d = ST_SORT;
			ST_SORT: if (scnt_q == SC_W'(N - 1)) state_d = ST_MEAN;
			ST_MEAN: if (mcnt_q == '0) state_d = (wcount_q >= window_q) ? ST_DIV : ST_SQRT;
			ST_DIV:  if (ddone) state_d = ST_OUT;
			ST_SQRT: state_d = ST_OUT;
			ST_OUT:  if (!out_full_q || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == ST_IDLE);
		go_out = (state_q == ST_OUT) && (!out_full_q || m_tready);
	end

	always_comb begin
		logic [RMS_W-1:0] v, lo, hi;
		v  = mode_q ? held_q : RMS_W'(filt);
		lo = mode_q ? ac_range_q : RMS_W'(dc_range_q);
		hi = mode_q ? ac_over_q : RMS_W'(dc_over_q);
		priority if (v < lo) range = RANGE_LOW;
		else if (v < hi) range = RANGE_HIGH;
		else range = RANGE_OVER;
	end

	assign sum_add = {1'b0, sum_q} + (SUM_W+1)'(sq_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mode_q <= 1'b0;
			dc_range_q <= 13'd1242;
			dc_over_q <= 13'd4096;
			ac_range_q <= RMS_W'(249);
			ac_over_q <= RMS_W'(2483);
			window_q <= WIN_W'(3600);
			divisor_q <= WIN_W'(1800);
			wcount_q <= '0;
			sum_q <= '0;
			held_q <= '0;
			prev_q <= RANGE_NONE;
			out_full_q <= 1'b0;
			scnt_q <= '0;
			mcnt_q <= '0;
			upd_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_MODE:     mode_q <= cfg_data[0];
					REG_DC_RANGE: dc_range_q <= cfg_data[12:0];
					REG_DC_OVER:  dc_over_q <= cfg_data[12:0];
					REG_AC_RANGE: ac_range_q <= cfg_data;
					REG_AC_OVER:  ac_over_q <= cfg_data;
					REG_WINDOW:   window_q <= cfg_data[WIN_W-1:0];
					REG_DIVISOR:  divisor_q <= cfg_data[WIN_W-1:0];
					default: ;
				endcase
			end
			if (accept) scnt_q <= '0;
			else if (state_q == ST_SORT) begin
				scnt_q <= scnt_q + 1'b1;
				if (scnt_q == SC_W'(N - 1)) mcnt_q <= MC_W'(MW);
			end
			if (state_q == ST_MEAN && mcnt_q != '0) mcnt_q <= mcnt_q - 1'b1;
			if (state_q == ST_MEAN && mcnt_q == '0) upd_q <= (wcount_q >= window_q);
			if (state_q == ST_SQRT) begin
				sum_q <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
				wcount_q <= wcount_q + 1'b1;
			end
			if (ddone) begin
				held_q <= droot;
				sum_q <= '0;
				wcount_q <= '0;
			end
			if (m_tvalid && m_tready) out_full_q <= 1'b0;
			if (go_out) begin
				out_full_q <= 1'b1;
				prev_q <= range;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < N; k++) s_q[k] <= s_tdata[k*ADC_BITS +: ADC_BITS];
		end else if (state_q == ST_SORT) begin
			for (int k = 0; k < N; k++) s_q[k] <= s_sw[k];
			msum_q <= MW'(s_sw[START]) + MW'(s_sw[START+1]) + MW'(s_sw[START+2]);
			mrem_q <= '0;
		end
		// serial divide by three, one quotient bit a cycle
		if (state_q == ST_MEAN && mcnt_q != '0) begin
			msum_q <= {msum_q[MW-2:0], 1'b0};
			if (mrem_sh >= 3'd3) begin
				mrem_q <= 2'(mrem_sh - 3'd3);
				mquo_q <= {mquo_q[MW-2:0], 1'b1};
			end else begin
				mrem_q <= mrem_sh[1:0];
				mquo_q <= {mquo_q[MW-2:0], 1'b0};
			end
		end
		if (state_q == ST_MEAN && mcnt_q == '0) sq_s1 <= filt * filt;
		if (go_out) begin
			o_filt_q <= filt;
			o_range_q <= range;
			o_chg_q <= (range != prev_q);
			o_rms_q <= held_q;
			o_upd_q <= upd_q;
		end
	end

	assign m_tvalid = out_full_q;
	assign m_tdata = OUT_W'({o_rms_q, o_range_q, o_filt_q});
	assign m_tuser = o_chg_q;
	assign m_tlast = o_upd_q;

`ifndef NO_ASSERTIONS
	a_busy_div: assert property (@(posedge clk) disable iff (!arst_n)
		dbusy |-> (state_q == ST_DIV)) else $error("divider busy outside div");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_tready) else $error("ready while working");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid) else $error("output dropped");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> (wcount_q < window_q)) else $error("window overrun");
`endif
endmodule
